[rtl/htd_pkg.sv]
// Shared types and constants for the Huffman tree symbol decoder.
// Used by the top level; depends on nothing else.

package htd_pkg;

    localparam int TREE_BYTES_DEF = 4096;
    localparam int WORD_BITS_DEF  = 16;

    localparam int ROOT_W      = 12;
    localparam int COUNT_W     = 16;
    localparam int SYM_W       = 8;
    localparam int TADDR_W     = 12;
    localparam int TBYTE_W     = 8;
    localparam int PTR_W       = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_OFFSET  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOL_COUNT = CFG_INDEX_W'(1);

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_LO,
        ST_RD_HI,
        ST_EVAL,
        ST_SYM,
        ST_FLUSH
    } htd_state_t;

endpackage

[rtl/htd_tree_mem.sv]
// Single-port byte-wide tree memory with registered read data.
// Stand-alone; instantiated by huffman_tree_symbol_decoder.

module htd_tree_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/huffman_tree_symbol_decoder.sv]
// Huffman tree symbol decoder: walks a byte-wide tree memory, one code bit at a time.
// Load: the tree byte is written as the item is accepted. Decode: per code bit used, a pointer
// low read, high read and evaluate on the single memory port; per symbol, a leaf read; a flush
// ends each word. Result stalls can hold the walk; one item is in flight at a time.
// Reset (aresetn low, synchronous) clears control, sets root_offset 0, symbol_count 1;
// the tree memory is not cleared and needs no clearing pass.

module huffman_tree_symbol_decoder #(
    parameter int TREE_BYTES = htd_pkg::TREE_BYTES_DEF,
    parameter int WORD_BITS  = htd_pkg::WORD_BITS_DEF,
    localparam int IN_TDATA_W =
        ((htd_pkg::TADDR_W + htd_pkg::TBYTE_W + WORD_BITS + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tdata: tree_address[11:0], tree_byte[19:12], code_word, zero fill
    input  logic [IN_TDATA_W-1:0]               s_tdata,
    // tuser: op
    input  logic [0:0]                          s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: symbol[7:0]
    output logic [htd_pkg::SYM_W-1:0]           m_tdata,
    // tuser: string_done
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [htd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [htd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import htd_pkg::*;

    localparam int ADDR_W = $clog2(TREE_BYTES);
    localparam int CNT_W  = $clog2(WORD_BITS + 1);

    htd_state_t state_reg, state_next;

    logic [ROOT_W-1:0]    root_offset_reg, root_offset_next;
    logic [COUNT_W-1:0]   symbol_count_reg, symbol_count_next;
    logic [COUNT_W-1:0]   symbols_left_reg, symbols_left_next;
    logic [ADDR_W-1:0]    node_reg, node_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [CNT_W-1:0]     bits_reg, bits_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [7:0]           lo_reg, lo_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0]     pend_sym_reg, pend_sym_next;
    logic                 pend_done_reg, pend_done_next;
    logic                 m_valid_reg, m_valid_next;
    logic [SYM_W-1:0]     m_sym_reg, m_sym_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_done_reg, m_done_next;

    logic [TADDR_W-1:0]   in_tree_address;
    logic [TBYTE_W-1:0]   in_tree_byte;
    logic [WORD_BITS-1:0] in_code_word;
    logic                 cur_bit;
    logic [ADDR_W-1:0]    root_addr;
    logic [ADDR_W-1:0]    addr_off;
    logic [ADDR_W-1:0]    walk_addr;
    logic [ADDR_W-1:0]    mem_addr;
    logic                 mem_we;
    logic [7:0]           mem_rdata;
    logic [PTR_W-1:0]     ptr;
    logic [COUNT_W-1:0]   left_dec;
    logic                 out_free;

    assign in_tree_address = s_tdata[TADDR_W-1:0];
    assign in_tree_byte    = s_tdata[TADDR_W +: TBYTE_W];
    assign in_code_word    = s_tdata[TADDR_W + TBYTE_W +: WORD_BITS];

    assign cur_bit   = word_reg[WORD_BITS-1];
    assign root_addr = ADDR_W'(root_offset_reg);
    assign ptr       = {mem_rdata, lo_reg};
    assign left_dec  = symbols_left_reg - COUNT_W'(1);
    assign out_free  = !m_valid_reg || m_tready;

    // Shared address adder: pointer bytes at node+0..3, leaf byte at node-1
    always_comb begin
        unique case (state_reg)
            ST_RD_LO: addr_off = cur_bit ? ADDR_W'(0) : ADDR_W'(2);
            ST_RD_HI: addr_off = cur_bit ? ADDR_W'(1) : ADDR_W'(3);
            default:  addr_off = '1;
        endcase
    end

    assign walk_addr = node_reg + addr_off;
    assign mem_we    = s_tvalid && s_tready && (s_tuser[0] == OP_LOAD);
    assign mem_addr  = mem_we ? ADDR_W'(in_tree_address) : walk_addr;

    htd_tree_mem #(
        .DEPTH  (TREE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_tree_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (in_tree_byte),
        .rdata (mem_rdata)
    );

    always_comb begin
        state_next        = state_reg;
        root_offset_next  = root_offset_reg;
        symbol_count_next = symbol_count_reg;
        symbols_left_next = symbols_left_reg;
        node_next         = node_reg;
        word_next         = word_reg;
        bits_next         = bits_reg;
        n_next            = n_reg;
        lo_next           = lo_reg;
        pend_valid_next   = pend_valid_reg;
        pend_sym_next     = pend_sym_reg;
        pend_done_next    = pend_done_reg;
        m_valid_next      = m_valid_reg;
        m_sym_next        = m_sym_reg;
        m_last_next       = m_last_reg;
        m_done_next       = m_done_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // Register write restarts the walk; drop writes to unknown indexes
        if (cfg_valid) begin
            if (cfg_index == CFG_ROOT_OFFSET) begin
                root_offset_next  = cfg_data[ROOT_W-1:0];
                node_next         = ADDR_W'(cfg_data[ROOT_W-1:0]);
                symbols_left_next = symbol_count_reg;
            end else if (cfg_index == CFG_SYMBOL_COUNT) begin
                symbol_count_next = cfg_data[COUNT_W-1:0];
                symbols_left_next = cfg_data[COUNT_W-1:0];
                node_next         = root_addr;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && (s_tuser[0] == OP_DECODE)) begin
                    word_next  = in_code_word;
                    bits_next  = CNT_W'(WORD_BITS);
                    n_next     = '0;
                    state_next = ST_RD_LO;
                end
            end
            ST_RD_LO: begin
                state_next = ST_RD_HI;
            end
            ST_RD_HI: begin
                lo_next    = mem_rdata;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (ptr != '0) begin
                    node_next  = ptr[ADDR_W-1:0];
                    word_next  = word_reg << 1;
                    bits_next  = bits_reg - CNT_W'(1);
                    state_next = (bits_reg == CNT_W'(1)) ? ST_FLUSH : ST_RD_LO;
                end else if (n_reg == CNT_W'(WORD_BITS)) begin
                    // result cap reached: drop rest of word, stay on the leaf
                    state_next = ST_FLUSH;
                end else begin
                    state_next = ST_SYM;
                end
            end
            ST_SYM: begin
                // leaf byte is on mem_rdata; hold address until the older symbol can leave
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_sym_next   = pend_sym_reg;
                        m_last_next  = 1'b0;
                        m_done_next  = pend_done_reg;
                    end
                    pend_valid_next = 1'b1;
                    pend_sym_next   = mem_rdata;
                    pend_done_next  = (left_dec == '0);
                    n_next          = n_reg + CNT_W'(1);
                    node_next       = root_addr;
                    if (left_dec == '0) begin
                        symbols_left_next = symbol_count_reg;
                        state_next        = ST_FLUSH;
                    end else begin
                        symbols_left_next = left_dec;
                        state_next        = ST_RD_LO;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_sym_next      = pend_sym_reg;
                    m_last_next     = 1'b1;
                    m_done_next     = pend_done_reg;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            root_offset_reg  <= '0;
            symbol_count_reg <= COUNT_W'(1);
            symbols_left_reg <= COUNT_W'(1);
            node_reg         <= '0;
            pend_valid_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
            n_reg            <= '0;
            bits_reg         <= '0;
        end else begin
            state_reg        <= state_next;
            root_offset_reg  <= root_offset_next;
            symbol_count_reg <= symbol_count_next;
            symbols_left_reg <= symbols_left_next;
            node_reg         <= node_next;
            pend_valid_reg   <= pend_valid_next;
            m_valid_reg      <= m_valid_next;
            n_reg            <= n_next;
            bits_reg         <= bits_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg      <= word_next;
        lo_reg        <= lo_next;
        pend_sym_reg  <= pend_sym_next;
        pend_done_reg <= pend_done_next;
        m_sym_reg     <= m_sym_next;
        m_last_reg    <= m_last_next;
        m_done_reg    <= m_done_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_sym_reg;
    assign m_tlast   = m_last_reg;
    assign m_tuser   = m_done_reg;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("pending symbol left over while accepting input");

    a_result_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= CNT_W'(WORD_BITS))
        else $error("more symbols than code bits in one word");

    a_eval_has_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |-> (bits_reg != '0))
        else $error("evaluating a node with no code bit left");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH && state_next == ST_IDLE) |=> !pend_valid_reg)
        else $error("word ended with a symbol still pending");
`endif

endmodule

[tb/huffman_tree_symbol_decoder_tb.sv]
// Self-checking testbench for the Huffman tree symbol decoder: tree loads, code words and
// register writes go in, decoded symbols are checked against an in-bench tree walk.
// Depends on htd_pkg and huffman_tree_symbol_decoder.

module huffman_tree_symbol_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import htd_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 150;   // longer than one full decode transaction
    localparam int RANDOM_ITEMS  = 210;
    localparam int IDLE_PERCENT  = 19;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = CFG_INDEX_W'(7);

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             run_last;
        logic             string_done;
    } sym_result_t;

    typedef enum logic [1:0] {ROW_LOAD, ROW_DECODE, ROW_CFG} step_kind_t;

    typedef struct packed {
        step_kind_t  kind;
        logic [11:0] where;   // tree address or register index
        logic [15:0] value;   // tree byte, code word or register data
        logic        typed;
        sym_result_t want;
    } directed_step_t;

    localparam sym_result_t NO_RESULT = '0;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic [39:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    huffman_tree_symbol_decoder DUT (.*);

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Tree walk state, kept in step with what has been sent
    logic [7:0]   tree_mem [4096];
    bit           tree_written [4096];
    logic [11:0]  root_reg  = '0;
    logic [15:0]  count_reg = 16'd1;
    logic [11:0]  walk_node = '0;
    logic [15:0]  syms_left = 16'd1;
    bit           touched_blank;

    sym_result_t  expected_syms [$];
    sym_result_t  word_syms [$];
    int           fail_count  = 0;
    int           cycle_count = 0;
    int           item_count  = 0;
    bit           calm = 1'b0;

    directed_step_t directed_steps [28] = '{
        '{ROW_CFG,    12'(CFG_ROOT_OFFSET),  16'd4095, 1'b0, NO_RESULT},
        // root at the top of memory, a leaf for either bit
        '{ROW_LOAD,   12'd4094, 16'h00A5, 1'b0, NO_RESULT},
        '{ROW_LOAD,   12'd4095, 16'h0000, 1'b0, NO_RESULT},
        '{ROW_LOAD,   12'd0,    16'h0000, 1'b0, NO_RESULT},
        '{ROW_LOAD,   12'd1,    16'h0000, 1'b0, NO_RESULT},
        '{ROW_LOAD,   12'd2,    16'h0000, 1'b0, NO_RESULT},
        '{ROW_DECODE, 12'd0,    16'hFFFF, 1'b1, '{8'hA5, 1'b1, 1'b1}},
        '{ROW_DECODE, 12'd0,    16'h0000, 1'b1, '{8'hA5, 1'b1, 1'b1}},
        // zero count: string ends only after 65536 symbols, root leaf hits the per-word cap
        '{ROW_CFG,    12'(CFG_SYMBOL_COUNT), 16'd0,    1'b0, NO_RESULT},
        '{ROW_DECODE, 12'd0,    16'h1234, 1'b0, NO_RESULT},
        '{ROW_CFG,    12'(CFG_SYMBOL_COUNT), 16'hFFFF, 1'b0, NO_RESULT},
        '{ROW_DECODE, 12'd0,    16'h5A5A, 1'b0, NO_RESULT},
        // bit 1 at the root now points to node 3 through a wrapping pointer 0xF003
        '{ROW_LOAD,   12'd4095, 16'h0003, 1'b0, NO_RESULT},
        '{ROW_LOAD,   12'd0,    16'h00F0, 1'b0, NO_RESULT},
        '{ROW_LOAD,   12'd3,    16'h0000, 1'b0, NO_RESULT},
        '{ROW_LOAD,   12'd4,    16'h0000, 1'b0, NO_RESULT},
        '{ROW_LOAD,   12'd5,    16'h0000, 1'b0, NO_RESULT},
        '{ROW_LOAD,   12'd6,    16'h0000, 1'b0, NO_RESULT},
        '{ROW_DECODE, 12'd0,    16'h8000, 1'b0, NO_RESULT},
        // last bit lands on a leaf, emitted at the start of the next word
        '{ROW_DECODE, 12'd0,    16'hFFFF, 1'b0, NO_RESULT},
        '{ROW_DECODE, 12'd0,    16'h0001, 1'b0, NO_RESULT},
        '{ROW_CFG,    12'(CFG_UNUSED_INDEX), 16'h1234, 1'b0, NO_RESULT},
        '{ROW_DECODE, 12'd0,    16'h7FFF, 1'b0, NO_RESULT},
        '{ROW_LOAD,   12'd4094, 16'h00FF, 1'b0, NO_RESULT},
        '{ROW_CFG,    12'(CFG_SYMBOL_COUNT), 16'd1,    1'b0, NO_RESULT},
        '{ROW_DECODE, 12'd0,    16'h0000, 1'b1, '{8'hFF, 1'b1, 1'b1}},
        '{ROW_CFG,    12'(CFG_SYMBOL_COUNT), 16'd3,    1'b0, NO_RESULT},
        '{ROW_DECODE, 12'd0,    16'hC3C3, 1'b0, NO_RESULT}
    };

    function automatic logic [7:0] read_tree(input logic [11:0] addr);
        if (!tree_written[addr])
            touched_blank = 1'b1;
        return tree_mem[addr];
    endfunction

    // Walk one code word from the current node; results land in word_syms
    task automatic walk_code_word(input logic [15:0] word, output bit clean);
        int          bits;
        int          n;
        logic        bit_v;
        logic [11:0] node_at;
        logic [15:0] ptr;
        sym_result_t res;
        word_syms.delete();
        touched_blank = 1'b0;
        bits = 16;
        n = 0;
        while (bits > 0) begin
            bit_v = word[bits-1];
            node_at = walk_node + (bit_v ? 12'd0 : 12'd2);
            ptr = {read_tree(node_at + 12'd1), read_tree(node_at)};
            if (ptr != 16'd0) begin
                walk_node = ptr[11:0];
                bits--;
            end else begin
                if (n >= 16)
                    break;
                res.symbol = read_tree(walk_node - 12'd1);
                res.run_last = 1'b0;
                syms_left = syms_left - 16'd1;
                res.string_done = (syms_left == 16'd0);
                walk_node = root_reg;
                word_syms.insert(word_syms.size(), res);
                n++;
                if (res.string_done) begin
                    syms_left = count_reg;
                    break;
                end
            end
        end
        if (n > 0)
            word_syms[n-1].run_last = 1'b1;
        clean = !touched_blank;
    endtask

    task automatic send_item(input logic op, input logic [11:0] addr,
                             input logic [7:0] tbyte, input logic [15:0] word);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tuser  <= op;
        s_tdata  <= {4'b0, word, tbyte, addr};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        item_count++;
    endtask

    task automatic load_byte(input logic [11:0] addr, input logic [7:0] val);
        tree_mem[addr] = val;
        tree_written[addr] = 1'b1;
        send_item(OP_LOAD, addr, val, 16'($urandom));
    endtask

    // Send a code word only if its walk stays inside written tree bytes
    task automatic decode_word(input logic [15:0] word, input bit use_typed,
                               input sym_result_t typed_res, output bit sent);
        logic [11:0] saved_node;
        logic [15:0] saved_left;
        bit          clean;
        saved_node = walk_node;
        saved_left = syms_left;
        walk_code_word(word, clean);
        if (!clean) begin
            walk_node = saved_node;
            syms_left = saved_left;
            sent = 1'b0;
            return;
        end
        if (use_typed)
            expected_syms.insert(expected_syms.size(), typed_res);
        else
            foreach (word_syms[i])
                expected_syms.insert(expected_syms.size(), word_syms[i]);
        send_item(OP_DECODE, 12'($urandom), 8'($urandom), word);
        sent = 1'b1;
    endtask

    // Hold off the sender until every expected symbol is in and the block is idle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_syms.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [7:0] index, input logic [15:0] data);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        if (index == CFG_ROOT_OFFSET || index == CFG_SYMBOL_COUNT) begin
            if (index == CFG_ROOT_OFFSET)
                root_reg = data[11:0];
            else
                count_reg = data;
            walk_node = root_reg;
            syms_left = count_reg;
        end
    endtask

    // Lay out a random tree of 5-byte nodes starting at root, then load it byte by byte
    task automatic plant_tree(input logic [11:0] root, input int nodes);
        logic [15:0] ptr_one [16];
        logic [15:0] ptr_zero [16];
        int          open_node [$];
        bit          open_side [$];
        int          pick;
        logic [11:0] at;
        logic [3:0]  high;
        for (int k = 0; k < 16; k++) begin
            ptr_one[k]  = '0;
            ptr_zero[k] = '0;
        end
        open_node.insert(open_node.size(), 0);
        open_side.insert(open_side.size(), 1'b1);
        open_node.insert(open_node.size(), 0);
        open_side.insert(open_side.size(), 1'b0);
        for (int k = 1; k < nodes; k++) begin
            pick = $urandom_range(open_node.size() - 1);
            at = root + 12'(5 * k);
            // random upper nibble exercises pointer wrap; keep the pointer nonzero
            high = 4'($urandom);
            if (at == 12'd0 && high == 4'd0)
                high = 4'hF;
            if (open_side[pick])
                ptr_one[open_node[pick]] = {high, at};
            else
                ptr_zero[open_node[pick]] = {high, at};
            open_node.delete(pick);
            open_side.delete(pick);
            open_node.insert(open_node.size(), k);
            open_side.insert(open_side.size(), 1'b1);
            open_node.insert(open_node.size(), k);
            open_side.insert(open_side.size(), 1'b0);
        end
        for (int k = 0; k < nodes; k++) begin
            at = root + 12'(5 * k);
            load_byte(at - 12'd1, 8'($urandom));
            load_byte(at,         ptr_one[k][7:0]);
            load_byte(at + 12'd1, ptr_one[k][15:8]);
            load_byte(at + 12'd2, ptr_zero[k][7:0]);
            load_byte(at + 12'd3, ptr_zero[k][15:8]);
        end
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    always @(posedge aclk)
        cycle_count <= cycle_count + 1;

    // Result side: random stalls, compare each transaction with the oldest expectation
    always @(posedge aclk) begin
        sym_result_t got;
        sym_result_t want;
        m_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata, m_tlast, m_tuser[0]};
            if (expected_syms.size() == 0) begin
                note_failure($sformatf("unexpected symbol %02h last %0d done %0d",
                                       got.symbol, got.run_last, got.string_done));
            end else begin
                want = expected_syms.pop_front();
                if (got.symbol !== want.symbol || got.run_last !== want.run_last ||
                    got.string_done !== want.string_done)
                    note_failure($sformatf(
                        "symbol mismatch: exp %02h/%0d/%0d got %02h/%0d/%0d",
                        want.symbol, want.run_last, want.string_done,
                        got.symbol, got.run_last, got.string_done));
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("huffman_tree_symbol_decoder regression: fail");
        $finish;
    end

    initial begin
        directed_step_t step;
        bit             sent;
        int             phase;
        int             first_random;
        int             nwords;
        logic [11:0]    tree_root;
        logic [15:0]    count_val;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_steps[i]) begin
            step = directed_steps[i];
            case (step.kind)
                ROW_LOAD:   load_byte(step.where, step.value[7:0]);
                ROW_DECODE: decode_word(step.value, step.typed, step.want, sent);
                default:    write_register(step.where[7:0], step.value);
            endcase
        end

        phase = 0;
        tree_root = '0;
        first_random = item_count;
        while (item_count - first_random < RANDOM_ITEMS) begin
            phase++;
            calm = (phase == 3 || phase == 4);
            if (phase == 1 || $urandom_range(2) != 0) begin
                case ($urandom_range(5))
                    0:       tree_root = 12'd0;
                    1:       tree_root = 12'd4095;
                    default: tree_root = 12'($urandom);
                endcase
                plant_tree(tree_root, $urandom_range(1, 9));
                write_register(CFG_ROOT_OFFSET, 16'(tree_root));
            end
            if ($urandom_range(5) == 0)
                write_register(8'($urandom_range(2, 255)), 16'($urandom));
            case ($urandom_range(7))
                0:       count_val = 16'd1;
                1:       count_val = 16'd0;
                2:       count_val = 16'hFFFF;
                3:       count_val = 16'($urandom);
                default: count_val = 16'($urandom_range(2, 24));
            endcase
            write_register(CFG_SYMBOL_COUNT, count_val);
            nwords = $urandom_range(6, 16);
            for (int w = 0; w < nwords; w++) begin
                // stray tree writes between words; the walk check skips words they break
                if ($urandom_range(7) == 0)
                    load_byte(12'($urandom), 8'($urandom));
                sent = 1'b0;
                for (int tries = 0; tries < 8 && !sent; tries++)
                    decode_word(16'($urandom), 1'b0, NO_RESULT, sent);
                if (!sent)
                    break;
            end
        end
        calm = 1'b0;

        drain_results();
        if (fail_count == 0)
            $display("huffman_tree_symbol_decoder regression: pass");
        else
            $display("huffman_tree_symbol_decoder regression: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/htd_pkg.sv
rtl/htd_tree_mem.sv
rtl/huffman_tree_symbol_decoder.sv
tb/huffman_tree_symbol_decoder_tb.sv
